FILE: design/ball_bounce_physics_step_macros.svh
// Assertion helpers for the ball bounce block.
`ifndef BALL_BOUNCE_PHYSICS_STEP_MACROS_SVH
`define BALL_BOUNCE_PHYSICS_STEP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define BBP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication checked outside reset.
`define BBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: design/bbp_pkg.sv
package bbp_pkg;

  localparam int MaxObstacles = 16;
  localparam int SlotW        = $clog2(MaxObstacles);

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_COLLIDE = 3'd1,
    OP_ADVANCE = 3'd2,
    OP_SETPOS  = 3'd3,
    OP_SETVEL  = 3'd4,
    OP_SETHOLD = 3'd5,
    OP_RSVD6   = 3'd6,
    OP_RSVD7   = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    REG_GRAVITY = 3'd0,
    REG_BOUNCE  = 3'd1,
    REG_RADIUS  = 3'd2,
    REG_WIDTH   = 3'd3,
    REG_HEIGHT  = 3'd4,
    REG_NOBS    = 3'd5,
    REG_RSVD6   = 3'd6,
    REG_RSVD7   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [3:0]         slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [8:0]         angle_deg;
    logic [15:0]        length;
    logic [15:0]        dt;
    logic               hold;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] ball_x;
    logic signed [31:0] ball_y;
    logic signed [31:0] ball_vx;
    logic signed [31:0] ball_vy;
    logic               is_held;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_GRAV,
    ST_EDGE_B,
    ST_EDGE_T,
    ST_EDGE_R,
    ST_EDGE_L,
    ST_OBS_RD,
    ST_OBS_TRIG,
    ST_OBS_MUL,
    ST_OBS_TEST,
    ST_OBS_DOT,
    ST_OBS_PROJ,
    ST_OBS_SCALE,
    ST_OBS_APPLY,
    ST_ADV_G,
    ST_ADV_VY,
    ST_ADV_X,
    ST_ADV_Y,
    ST_DONE
  } state_t;

  // Datapath operations selected by the controller.
  typedef enum logic [4:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_SIMPLE,
    DP_GRAV,
    DP_EDGE_B,
    DP_EDGE_T,
    DP_EDGE_R,
    DP_EDGE_L,
    DP_OBS_RD,
    DP_OBS_TRIG,
    DP_OBS_MUL,
    DP_OBS_TEST,
    DP_OBS_DOT,
    DP_OBS_PROJ,
    DP_OBS_SCALE,
    DP_OBS_APPLY,
    DP_ADV_G,
    DP_ADV_VY,
    DP_ADV_X,
    DP_ADV_Y
  } dp_op_t;

  typedef struct packed {
    dp_op_t   op;
    logic     obs_clr;
    logic     obs_inc;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t  opcode;
    logic     held;
    logic     obs_more;
    logic     hit;
    logic     dot_neg;
  } dp_sts_t;

  // Saturate a 40-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = 32'sh7fffffff;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Round-to-nearest shift by 16, ties away from zero.
  function automatic logic signed [63:0] rshr16(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] q;
    m = v[63] ? 64'(-v) : 64'(v);
    q = (m + 64'h8000) >> 16;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [63:0] rshr15(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] q;
    m = v[63] ? 64'(-v) : 64'(v);
    q = (m + 64'h4000) >> 15;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

  // Quarter sine, Q1.15, entries 0..90 degrees.
  function automatic logic [14:0] qsin(input logic [6:0] k);
    logic [14:0] r;
    case (k)
      7'd0: r = 15'd0;      7'd1: r = 15'd572;    7'd2: r = 15'd1144;
      7'd3: r = 15'd1715;   7'd4: r = 15'd2286;   7'd5: r = 15'd2856;
      7'd6: r = 15'd3425;   7'd7: r = 15'd3993;   7'd8: r = 15'd4560;
      7'd9: r = 15'd5126;   7'd10: r = 15'd5690;  7'd11: r = 15'd6252;
      7'd12: r = 15'd6813;  7'd13: r = 15'd7371;  7'd14: r = 15'd7927;
      7'd15: r = 15'd8481;  7'd16: r = 15'd9032;  7'd17: r = 15'd9580;
      7'd18: r = 15'd10126; 7'd19: r = 15'd10668; 7'd20: r = 15'd11207;
      7'd21: r = 15'd11743; 7'd22: r = 15'd12275; 7'd23: r = 15'd12803;
      7'd24: r = 15'd13328; 7'd25: r = 15'd13848; 7'd26: r = 15'd14365;
      7'd27: r = 15'd14876; 7'd28: r = 15'd15384; 7'd29: r = 15'd15886;
      7'd30: r = 15'd16384; 7'd31: r = 15'd16877; 7'd32: r = 15'd17364;
      7'd33: r = 15'd17847; 7'd34: r = 15'd18324; 7'd35: r = 15'd18795;
      7'd36: r = 15'd19261; 7'd37: r = 15'd19720; 7'd38: r = 15'd20174;
      7'd39: r = 15'd20622; 7'd40: r = 15'd21063; 7'd41: r = 15'd21498;
      7'd42: r = 15'd21926; 7'd43: r = 15'd22348; 7'd44: r = 15'd22763;
      7'd45: r = 15'd23170; 7'd46: r = 15'd23571; 7'd47: r = 15'd23965;
      7'd48: r = 15'd24351; 7'd49: r = 15'd24730; 7'd50: r = 15'd25102;
      7'd51: r = 15'd25466; 7'd52: r = 15'd25822; 7'd53: r = 15'd26170;
      7'd54: r = 15'd26510; 7'd55: r = 15'd26842; 7'd56: r = 15'd27166;
      7'd57: r = 15'd27482; 7'd58: r = 15'd27789; 7'd59: r = 15'd28088;
      7'd60: r = 15'd28378; 7'd61: r = 15'd28660; 7'd62: r = 15'd28932;
      7'd63: r = 15'd29197; 7'd64: r = 15'd29452; 7'd65: r = 15'd29698;
      7'd66: r = 15'd29935; 7'd67: r = 15'd30163; 7'd68: r = 15'd30382;
      7'd69: r = 15'd30592; 7'd70: r = 15'd30792; 7'd71: r = 15'd30983;
      7'd72: r = 15'd31164; 7'd73: r = 15'd31336; 7'd74: r = 15'd31499;
      7'd75: r = 15'd31651; 7'd76: r = 15'd31795; 7'd77: r = 15'd31928;
      7'd78: r = 15'd32052; 7'd79: r = 15'd32166; 7'd80: r = 15'd32270;
      7'd81: r = 15'd32365; 7'd82: r = 15'd32449; 7'd83: r = 15'd32524;
      7'd84: r = 15'd32588; 7'd85: r = 15'd32643; 7'd86: r = 15'd32688;
      7'd87: r = 15'd32723; 7'd88: r = 15'd32748; 7'd89: r = 15'd32763;
      default: r = 15'd32767;
    endcase
    return r;
  endfunction

  // Full-circle sine from the quarter table, angle 0..359.
  function automatic logic signed [16:0] sin_deg(input logic [8:0] a);
    logic signed [16:0] r;
    if (a <= 9'd90) r = $signed({2'b00, qsin(7'(a))});
    else if (a <= 9'd180) r = $signed({2'b00, qsin(7'(9'd180 - a))});
    else if (a <= 9'd270) r = -$signed({2'b00, qsin(7'(a - 9'd180))});
    else r = -$signed({2'b00, qsin(7'(9'd360 - a))});
    return r;
  endfunction

endpackage

FILE: design/bbp_ram.sv
module bbp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/bbp_ctrl.sv
module bbp_ctrl
  import bbp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output logic    done,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state_r, state_nxt;

  // Hold the state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence the datapath.
  always_comb begin
    state_nxt   = state_r;
    cmd.op      = DP_NOP;
    cmd.obs_clr = 1'b0;
    cmd.obs_inc = 1'b0;
    busy        = (state_r != ST_IDLE);
    done        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.op    = DP_CAPTURE;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.obs_clr = 1'b1;
        case (sts.opcode)
          OP_COLLIDE: state_nxt = sts.held ? ST_DONE : ST_GRAV;
          OP_ADVANCE: state_nxt = ST_ADV_G;
          default: begin
            cmd.op    = DP_SIMPLE;
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_GRAV:   begin cmd.op = DP_GRAV;   state_nxt = ST_EDGE_B; end
      ST_EDGE_B: begin cmd.op = DP_EDGE_B; state_nxt = ST_EDGE_T; end
      ST_EDGE_T: begin cmd.op = DP_EDGE_T; state_nxt = ST_EDGE_R; end
      ST_EDGE_R: begin cmd.op = DP_EDGE_R; state_nxt = ST_EDGE_L; end
      ST_EDGE_L: begin cmd.op = DP_EDGE_L; state_nxt = ST_OBS_RD; end
      ST_OBS_RD: begin
        if (sts.obs_more) begin
          cmd.op    = DP_OBS_RD;
          state_nxt = ST_OBS_TRIG;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_OBS_TRIG: begin cmd.op = DP_OBS_TRIG; state_nxt = ST_OBS_MUL; end
      ST_OBS_MUL:  begin cmd.op = DP_OBS_MUL;  state_nxt = ST_OBS_TEST; end
      ST_OBS_TEST: begin
        cmd.op    = DP_OBS_TEST;
        state_nxt = ST_OBS_DOT;
      end
      ST_OBS_DOT: begin
        if (sts.hit) begin
          cmd.op    = DP_OBS_DOT;
          state_nxt = ST_OBS_PROJ;
        end else begin
          cmd.obs_inc = 1'b1;
          state_nxt   = ST_OBS_RD;
        end
      end
      ST_OBS_PROJ: begin
        if (sts.dot_neg) begin
          cmd.op    = DP_OBS_PROJ;
          state_nxt = ST_OBS_SCALE;
        end else begin
          cmd.obs_inc = 1'b1;
          state_nxt   = ST_OBS_RD;
        end
      end
      ST_OBS_SCALE: begin cmd.op = DP_OBS_SCALE; state_nxt = ST_OBS_APPLY; end
      ST_OBS_APPLY: begin
        cmd.op      = DP_OBS_APPLY;
        cmd.obs_inc = 1'b1;
        state_nxt   = ST_OBS_RD;
      end
      ST_ADV_G:  begin cmd.op = DP_ADV_G;  state_nxt = ST_ADV_VY; end
      ST_ADV_VY: begin cmd.op = DP_ADV_VY; state_nxt = ST_ADV_X; end
      ST_ADV_X:  begin cmd.op = DP_ADV_X;  state_nxt = ST_ADV_Y; end
      ST_ADV_Y:  begin cmd.op = DP_ADV_Y;  state_nxt = ST_DONE; end
      ST_DONE: begin
        done      = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: design/bbp_dp.sv
module bbp_dp
  import bbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  output out_item_t   state_out
);

  // Configuration registers.
  logic signed [31:0] gravity_r;
  logic [17:0]        bounce_r;
  logic [9:0]         radius_r;
  logic [11:0]        width_r;
  logic [11:0]        height_r;
  logic [4:0]         nobs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r <= '0;
      bounce_r  <= 18'd52429;
      radius_r  <= 10'd10;
      width_r   <= 12'd800;
      height_r  <= 12'd600;
      nobs_r    <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_GRAVITY: gravity_r <= cfg_data;
        REG_BOUNCE:  bounce_r  <= cfg_data[17:0];
        REG_RADIUS:  radius_r  <= cfg_data[9:0];
        REG_WIDTH:   width_r   <= cfg_data[11:0];
        REG_HEIGHT:  height_r  <= cfg_data[11:0];
        REG_NOBS:    nobs_r    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Ball state and captured item.
  logic signed [31:0] x_r, y_r, vx_r, vy_r;
  logic               held_r;
  in_item_t           item_r;

  // Obstacle walk and intermediates.
  logic [SlotW:0]     idx_r;
  logic signed [16:0] s_r, c_r;
  logic signed [63:0] t_r, d_r, dot_r, px_r, py_r;
  logic               hit_r;

  // Obstacle table, one memory for all fields.
  localparam int ObsW = 32 + 32 + 9 + 16;
  logic [ObsW-1:0] obs_rd;
  logic            obs_we;

  assign obs_we = (cmd.op == DP_SIMPLE) && (item_r.opcode == OP_LOAD);

  bbp_ram #(.Width(ObsW), .Depth(MaxObstacles)) u_obs_ram (
    .clk   (clk),
    .we    (obs_we),
    .waddr (item_r.slot[SlotW-1:0]),
    .wdata ({item_r.pos_x, item_r.pos_y, item_r.angle_deg, item_r.length}),
    .raddr (idx_r[SlotW-1:0]),
    .rdata (obs_rd)
  );

  logic signed [31:0] ox, oy;
  logic [8:0]         oang, aang, cang;
  logic [15:0]        olen;
  assign ox   = obs_rd[88:57];
  assign oy   = obs_rd[56:25];
  assign oang = obs_rd[24:16];
  assign olen = obs_rd[15:0];
  assign aang = (oang >= 9'd360) ? oang - 9'd360 : oang;
  assign cang = (aang >= 9'd270) ? aang - 9'd270 : aang + 9'd90;

  logic [4:0] cnt;
  assign cnt = (nobs_r > 5'(MaxObstacles)) ? 5'(MaxObstacles) : nobs_r;

  // Shared arithmetic for edges, sums and scaling.
  logic signed [39:0] lim_b, lim_r, r16;
  logic signed [32:0] dx, dy;
  logic signed [63:0] bsc_vy, bsc_vx, gdt, vxdt, vydt;
  assign r16   = $signed({14'd0, radius_r, 16'd0});
  assign lim_b = ($signed({28'd0, height_r}) - $signed({30'd0, radius_r})) <<< 16;
  assign lim_r = ($signed({28'd0, width_r}) - $signed({30'd0, radius_r})) <<< 16;
  assign dx    = 33'(x_r) - 33'(ox);
  assign dy    = 33'(y_r) - 33'(oy);
  assign bsc_vy = rshr16(64'(vy_r) * $signed({46'd0, bounce_r}));
  assign bsc_vx = rshr16(64'(vx_r) * $signed({46'd0, bounce_r}));
  assign gdt    = rshr16(64'(gravity_r) * $signed({48'd0, item_r.dt}));
  assign vxdt   = rshr16(64'(vx_r) * $signed({48'd0, item_r.dt}));
  assign vydt   = rshr16(64'(vy_r) * $signed({48'd0, item_r.dt}));

  logic signed [63:0] dabs, r31, lenl, d16;
  assign dabs = d_r[63] ? -d_r : d_r;
  assign r31  = $signed({23'd0, radius_r, 31'd0});
  assign lenl = $signed({17'd0, olen, 31'd0});
  assign d16  = rshr15(dot_r);

  // Apply the controller command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      vx_r   <= '0;
      vy_r   <= '0;
      held_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (cmd.obs_clr) idx_r <= '0;
      else if (cmd.obs_inc) idx_r <= idx_r + 1'b1;
      case (cmd.op)
        DP_CAPTURE: item_r <= in_item;
        DP_SIMPLE: begin
          case (opcode_t'(item_r.opcode))
            OP_SETPOS:  begin x_r <= item_r.pos_x; y_r <= item_r.pos_y; end
            OP_SETVEL:  begin vx_r <= item_r.vel_x; vy_r <= item_r.vel_y; end
            OP_SETHOLD: held_r <= item_r.hold;
            default: ;
          endcase
        end
        DP_GRAV: vy_r <= sat32(40'(vy_r) + 40'(gravity_r));
        DP_EDGE_B: if (40'(y_r) >= lim_b) begin
          y_r  <= lim_b[31:0];
          vy_r <= sat32(-40'(bsc_vy));
        end
        DP_EDGE_T: if (40'(y_r) <= r16) begin
          y_r  <= r16[31:0];
          vy_r <= sat32(-40'(bsc_vy));
        end
        DP_EDGE_R: if (40'(x_r) >= lim_r) begin
          x_r  <= lim_r[31:0];
          vx_r <= sat32(-40'(bsc_vx));
        end
        DP_EDGE_L: if (40'(x_r) <= r16) begin
          x_r  <= r16[31:0];
          vx_r <= sat32(-40'(bsc_vx));
        end
        DP_OBS_RD: ;
        DP_OBS_TRIG: begin
          s_r <= sin_deg(aang);
          c_r <= sin_deg(cang);
        end
        DP_OBS_MUL: begin
          t_r <= 64'(dx) * 64'(c_r) + 64'(dy) * 64'(s_r);
          d_r <= 64'(dx) * 64'(s_r) - 64'(dy) * 64'(c_r);
        end
        DP_OBS_TEST: hit_r <= (dabs <= r31) && !t_r[63] && (t_r <= lenl);
        DP_OBS_DOT: dot_r <= 64'(vx_r) * 64'(s_r) - 64'(vy_r) * 64'(c_r);
        DP_OBS_PROJ: begin
          px_r <= rshr15(d16 * 64'(s_r));
          py_r <= rshr15(d16 * -64'(c_r));
        end
        DP_OBS_SCALE: begin
          px_r <= rshr16(px_r * $signed({46'd0, bounce_r}));
          py_r <= rshr16(py_r * $signed({46'd0, bounce_r}));
        end
        DP_OBS_APPLY: begin
          vx_r <= sat32(40'(vx_r) - 40'(px_r <<< 1));
          vy_r <= sat32(40'(vy_r) - 40'(py_r <<< 1));
        end
        DP_ADV_G:  vy_r <= sat32(40'(vy_r) + 40'(gdt));
        DP_ADV_VY: ;
        DP_ADV_X:  x_r <= sat32(40'(x_r) + 40'(vxdt));
        DP_ADV_Y:  y_r <= sat32(40'(y_r) + 40'(vydt));
        default: ;
      endcase
    end
  end

  // Status back to the controller.
  always_comb begin
    sts.opcode   = opcode_t'(item_r.opcode);
    sts.held     = held_r;
    sts.obs_more = (idx_r < (SlotW+1)'(cnt));
    sts.hit      = hit_r;
    sts.dot_neg  = dot_r[63];
  end

  assign state_out = '{ball_x: x_r, ball_y: y_r, ball_vx: vx_r,
                       ball_vy: vy_r, is_held: held_r};

endmodule

FILE: design/ball_bounce_physics_step.sv
// Ball bounce physics step.
// Pulse start with busy low to issue one transaction on in_item; the block
// raises busy until it is finished. Ops: load obstacle, collide, advance,
// set position, set velocity, set hold.
// Each transaction yields one result on out_item, marked by out_valid for
// exactly one cycle; the receiver cannot stall, so the result is simply
// dropped onto the ports.
// Collide walks the obstacle table one entry at a time (through the
// registered table read and the shared multiply stages): an obstacle
// missed ends after the hit test, one touched with outward velocity
// after the dot product, and one reflected also goes through the
// projection, scaling and apply steps. A held collide skips gravity,
// the edges and the walk. A new transaction is taken at the earliest
// in the cycle after out_valid.
// Configuration writes via cfg_we/cfg_idx/cfg_data take effect next cycle;
// the user must issue them only while idle, the block does not enforce it.
// Reset (rst_n low, synchronous) zeroes the ball state, clears hold and
// restores the register defaults; the obstacle table is undefined until
// loaded.
module ball_bounce_physics_step
  import bbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data
);

`include "ball_bounce_physics_step_macros.svh"

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  logic      done;

  bbp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  bbp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .state_out (out_item)
  );

  assign out_valid = done;

  // A result follows only work in flight; idle start begins a transaction.
  `BBP_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `BBP_ASSERT_NEXT(a_done_idle, out_valid, !busy)
  `BBP_ASSERT_IMP(a_done_busy, out_valid, busy)

endmodule

FILE: test/ball_bounce_physics_step_checker.sv
`timescale 1ns / 1ps

// Watches the command, result and register ports, keeps its own copy of the
// ball, the obstacle table and the registers, and compares every result.
module ball_bounce_physics_step_checker
  import bbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  input  logic      cfg_we,
  input  logic [2:0] cfg_idx,
  input  logic [31:0] cfg_data,
  output int        errors,
  output int        pending,
  output int        results_seen,
  output int        reflections_seen
);

  localparam longint ONE_Q16 = 64'sd65536;
  localparam longint ONE_Q31 = 64'sd2147483648;

  longint sine_q15 [360];

  // Ball and obstacle state
  longint ball_x, ball_y, ball_vx, ball_vy;
  bit     ball_held;
  longint obs_x [MaxObstacles];
  longint obs_y [MaxObstacles];
  int     obs_angle [MaxObstacles];
  longint obs_len [MaxObstacles];

  // Register copies
  longint gravity, bounce, radius, width_px, height_px, obs_count;

  out_item_t ball_states_due [$];

  // Build the Q1.15 sine table from a Taylor series in Q30
  function automatic void build_sine_table();
    longint unsigned x, x2, term, q;
    longint s;
    longint quarter [91];
    for (int k = 0; k <= 90; k++) begin
      x = (longint'(k) * 64'd3373259426 + 64'd90) / 64'd180;
      x2 = (x * x) >> 30;
      term = x;
      s = x;
      for (int n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) s -= term;
        else s += term;
      end
      if (s < 0) s = 0;
      q = (longint'(s) + 64'd16384) >> 15;
      if (q > 64'd32767) q = 64'd32767;
      quarter[k] = q;
    end
    for (int k = 0; k < 360; k++) begin
      if (k <= 90) sine_q15[k] = quarter[k];
      else if (k <= 180) sine_q15[k] = quarter[180 - k];
      else if (k <= 270) sine_q15[k] = -quarter[k - 180];
      else sine_q15[k] = -quarter[360 - k];
    end
  endfunction

  // Shift right with rounding to nearest, ties away from zero
  function automatic longint round_shift(longint v, int sh);
    longint unsigned half, m;
    half = 64'd1 << (sh - 1);
    if (v < 0) begin
      m = -v;
      return -longint'((m + half) >> sh);
    end
    m = v;
    return longint'((m + half) >> sh);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint apply_bounce(longint v);
    return round_shift(v * bounce, 16);
  endfunction

  // Gravity, field edges, then the obstacle walk
  function automatic void collide_ball();
    longint lim, r16, r31, cnt, s, c, nx, ny, dx, dy, t, d, dot, d16, px, py;
    int a;
    if (ball_held) return;
    ball_vy = clip32(ball_vy + gravity);
    r16 = radius * ONE_Q16;
    lim = (height_px - radius) * ONE_Q16;
    if (ball_y >= lim) begin
      ball_y = lim;
      ball_vy = clip32(-apply_bounce(ball_vy));
    end
    if (ball_y <= r16) begin
      ball_y = r16;
      ball_vy = clip32(-apply_bounce(ball_vy));
    end
    lim = (width_px - radius) * ONE_Q16;
    if (ball_x >= lim) begin
      ball_x = lim;
      ball_vx = clip32(-apply_bounce(ball_vx));
    end
    if (ball_x <= r16) begin
      ball_x = r16;
      ball_vx = clip32(-apply_bounce(ball_vx));
    end
    r31 = radius * ONE_Q31;
    cnt = (obs_count > MaxObstacles) ? MaxObstacles : obs_count;
    for (int i = 0; i < cnt; i++) begin
      a = obs_angle[i];
      if (a >= 360) a -= 360;
      s = sine_q15[a];
      c = sine_q15[(a + 90) % 360];
      nx = s;
      ny = -c;
      dx = ball_x - obs_x[i];
      dy = ball_y - obs_y[i];
      t = dx * c + dy * s;
      d = dx * nx + dy * ny;
      if (d < 0) d = -d;
      if (d <= r31 && t >= 0 && t <= obs_len[i] * ONE_Q31) begin
        dot = ball_vx * nx + ball_vy * ny;
        if (dot < 0) begin
          d16 = round_shift(dot, 15);
          px = apply_bounce(round_shift(d16 * nx, 15));
          py = apply_bounce(round_shift(d16 * ny, 15));
          ball_vx = clip32(ball_vx - 2 * px);
          ball_vy = clip32(ball_vy - 2 * py);
          reflections_seen++;
        end
      end
    end
  endfunction

  // Apply one transaction and return the ball state after it
  function automatic out_item_t predict_ball_state(in_item_t it);
    out_item_t r;
    longint dt;
    case (opcode_t'(it.opcode))
      OP_LOAD: begin
        obs_x[it.slot] = $signed(it.pos_x);
        obs_y[it.slot] = $signed(it.pos_y);
        obs_angle[it.slot] = it.angle_deg;
        obs_len[it.slot] = it.length;
      end
      OP_COLLIDE: collide_ball();
      OP_ADVANCE: begin
        dt = it.dt;
        ball_vy = clip32(ball_vy + round_shift(gravity * dt, 16));
        ball_x = clip32(ball_x + round_shift(ball_vx * dt, 16));
        ball_y = clip32(ball_y + round_shift(ball_vy * dt, 16));
      end
      OP_SETPOS: begin
        ball_x = $signed(it.pos_x);
        ball_y = $signed(it.pos_y);
      end
      OP_SETVEL: begin
        ball_vx = $signed(it.vel_x);
        ball_vy = $signed(it.vel_y);
      end
      OP_SETHOLD: ball_held = it.hold;
      default: ;
    endcase
    r.ball_x = ball_x[31:0];
    r.ball_y = ball_y[31:0];
    r.ball_vx = ball_vx[31:0];
    r.ball_vy = ball_vy[31:0];
    r.is_held = ball_held;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("%0t mismatch %s: expected %0d got %0d", $time, what, want, got);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
    reflections_seen = 0;
    build_sine_table();
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      ball_x = 0;
      ball_y = 0;
      ball_vx = 0;
      ball_vy = 0;
      ball_held = 0;
      gravity = 0;
      bounce = 52429;
      radius = 10;
      width_px = 800;
      height_px = 600;
      obs_count = 0;
      ball_states_due.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (reg_idx_t'(cfg_idx))
          REG_GRAVITY: gravity = $signed(cfg_data);
          REG_BOUNCE:  bounce = cfg_data[17:0];
          REG_RADIUS:  radius = cfg_data[9:0];
          REG_WIDTH:   width_px = cfg_data[11:0];
          REG_HEIGHT:  height_px = cfg_data[11:0];
          REG_NOBS:    obs_count = cfg_data[4:0];
          default: ;
        endcase
      end
      // Compare a result against the oldest prediction
      if (out_valid) begin
        results_seen++;
        if (ball_states_due.size() == 0) begin
          $display("%0t result with no transaction outstanding", $time);
          errors++;
        end else begin
          want = ball_states_due.pop_front();
          if (out_item.ball_x !== want.ball_x)
            report_mismatch("ball_x", want.ball_x, out_item.ball_x);
          if (out_item.ball_y !== want.ball_y)
            report_mismatch("ball_y", want.ball_y, out_item.ball_y);
          if (out_item.ball_vx !== want.ball_vx)
            report_mismatch("ball_vx", want.ball_vx, out_item.ball_vx);
          if (out_item.ball_vy !== want.ball_vy)
            report_mismatch("ball_vy", want.ball_vy, out_item.ball_vy);
          if (out_item.is_held !== want.is_held)
            report_mismatch("is_held", want.is_held, out_item.is_held);
        end
      end
      // Predict each accepted transaction
      if (start && !busy) ball_states_due.push_back(predict_ball_state(in_item));
    end
    pending = ball_states_due.size();
  end

endmodule

FILE: test/ball_bounce_physics_step_test.sv
`timescale 1ns / 1ps

module ball_bounce_physics_step_test;
  import bbp_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_data;

  int errors, pending, results_seen, reflections_seen;
  int sent;
  int settings_done;
  int idle_pct;

  ball_bounce_physics_step DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  ball_bounce_physics_step_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .results_seen(results_seen),
    .reflections_seen(reflections_seen)
  );

  always #1 clk = ~clk;

  // Hard stop if the block hangs
  initial begin
    #2000000;
    $display("ball_bounce_physics_step_test: errors");
    $finish;
  end

  // Coordinate mostly inside a modest field, sometimes anywhere
  function automatic logic [31:0] field_coord();
    int p;
    if ($urandom_range(9) < 8) begin
      p = int'($urandom_range(0, 900)) - 50;
      return p * 65536 + int'($urandom_range(0, 65535));
    end
    return $urandom;
  endfunction

  function automatic logic [31:0] ball_speed();
    if ($urandom_range(9) < 8)
      return (int'($urandom_range(0, 400)) - 200) * 65536 + int'($urandom_range(0, 65535));
    return $urandom;
  endfunction

  function automatic in_item_t random_transaction();
    logic [191:0] raw;
    in_item_t it;
    int pick;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[176:0];
    pick = $urandom_range(99);
    if (pick < 10) begin
      it.opcode = OP_LOAD;
      it.pos_x = field_coord();
      it.pos_y = field_coord();
      it.angle_deg = 9'($urandom_range(0, 511));
      it.length = 16'(($urandom_range(9) < 8) ? $urandom_range(0, 900) : $urandom);
    end else if (pick < 45) begin
      it.opcode = OP_COLLIDE;
    end else if (pick < 65) begin
      it.opcode = OP_ADVANCE;
      it.dt = 16'(($urandom_range(9) < 8) ? $urandom_range(0, 4000) : $urandom);
    end else if (pick < 75) begin
      it.opcode = OP_SETPOS;
      it.pos_x = field_coord();
      it.pos_y = field_coord();
    end else if (pick < 85) begin
      it.opcode = OP_SETVEL;
      it.vel_x = ball_speed();
      it.vel_y = ball_speed();
    end else if (pick < 92) begin
      it.opcode = OP_SETHOLD;
    end else begin
      it.opcode = ($urandom_range(1)) ? OP_RSVD6 : OP_RSVD7;
    end
    return it;
  endfunction

  // Hold start high until the block takes the transaction
  task automatic issue(in_item_t it);
    in_item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic issue_op(opcode_t op, logic [3:0] slot, logic [31:0] x, logic [31:0] y,
                          logic [8:0] ang, logic [15:0] len, logic [15:0] dt, logic hold);
    in_item_t it;
    it = '0;
    it.opcode = op;
    it.slot = slot;
    it.pos_x = x;
    it.pos_y = y;
    it.vel_x = x;
    it.vel_y = y;
    it.angle_deg = ang;
    it.length = len;
    it.dt = dt;
    it.hold = hold;
    issue(it);
  endtask

  // Drain all results and let the block go idle
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  // One register write; the caller lowers cfg_we after a sequence
  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  task automatic write_setting(logic [31:0] g, logic [31:0] b, logic [31:0] r,
                               logic [31:0] w, logic [31:0] h, logic [31:0] n);
    settle();
    write_reg(REG_GRAVITY, g);
    write_reg(REG_BOUNCE, b);
    write_reg(REG_RADIUS, r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_NOBS, n);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_done++;
  endtask

  task automatic random_run(int count, int pct);
    idle_pct = pct;
    repeat (count) issue(random_transaction());
  endtask

  initial begin
    int total;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    sent = 0;
    settings_done = 0;
    idle_pct = 38;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load every slot first so no collide reads an empty entry
    for (int s = 0; s < MaxObstacles; s++) begin
      case (s)
        0: issue_op(OP_LOAD, 4'(s), 32'h7fffffff, 32'h80000000, 9'd0, 16'hffff, 0, 0);
        1: issue_op(OP_LOAD, 4'(s), 32'h80000000, 32'h7fffffff, 9'd511, 16'd0, 0, 0);
        2: issue_op(OP_LOAD, 4'(s), 100 << 16, 300 << 16, 9'd90, 16'd600, 0, 0);
        3: issue_op(OP_LOAD, 4'(s), 400 << 16, 100 << 16, 9'd360, 16'd400, 0, 0);
        4: issue_op(OP_LOAD, 4'(s), 700 << 16, 500 << 16, 9'd180, 16'd500, 0, 0);
        5: issue_op(OP_LOAD, 4'(s), 300 << 16, 550 << 16, 9'd270, 16'd300, 0, 0);
        6: issue_op(OP_LOAD, 4'(s), 50 << 16, 50 << 16, 9'd359, 16'd800, 0, 0);
        default: issue_op(OP_LOAD, 4'(s), field_coord(), field_coord(),
                          9'($urandom_range(0, 511)), 16'($urandom_range(0, 900)), 0, 0);
      endcase
    end
    // Ball extremes, hold, reserved opcodes, advance extremes
    issue_op(OP_SETPOS, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0);
    issue_op(OP_SETVEL, 0, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0);
    issue_op(OP_ADVANCE, 0, 0, 0, 0, 0, 16'hffff, 0);
    issue_op(OP_SETHOLD, 0, 0, 0, 0, 0, 0, 1'b1);
    issue_op(OP_COLLIDE, 0, 0, 0, 0, 0, 0, 0);
    issue_op(OP_ADVANCE, 0, 0, 0, 0, 0, 16'd0, 0);
    issue_op(OP_RSVD6, 0, 0, 0, 0, 0, 0, 0);
    issue_op(OP_RSVD7, 0, 0, 0, 0, 0, 0, 0);
    issue_op(OP_SETHOLD, 0, 0, 0, 0, 0, 0, 1'b0);
    issue_op(OP_COLLIDE, 0, 0, 0, 0, 0, 0, 0);

    // Ordinary field, all obstacles active
    write_setting(32'd642252, 32'd52429, 32'd10, 32'd800, 32'd600, 32'd16);
    random_run(200, 38);
    // Strongest gravity, bounce of 2.0, huge ball, too many obstacles
    write_setting(32'h7fffffff, 32'd131072, 32'd1023, 32'd1, 32'd4095, 32'd31);
    random_run(150, 79);
    // Weakest gravity, no bounce, tiny ball, no obstacles, unknown register
    write_setting(32'h80000000, 32'd0, 32'd1, 32'd4095, 32'd1, 32'd0);
    write_reg(REG_RSVD6, $urandom);
    write_reg(REG_RSVD7, $urandom);
    cfg_we <= 1'b0;
    @(posedge clk);
    random_run(150, 0);
    // Random moderate setting
    write_setting(int'($urandom_range(0, 2000000)) - 1000000, $urandom_range(0, 131072),
                  $urandom_range(1, 40), $urandom_range(200, 1000),
                  $urandom_range(200, 1000), $urandom_range(0, 20));
    random_run(280, 0);

    settle();
    total = errors + pending;
    $display("covered %0d transactions under %0d register settings", sent, settings_done);
    $display("checked %0d results, %0d obstacle reflections", results_seen, reflections_seen);
    if (total == 0) begin
      $display("ball_bounce_physics_step_test: clean");
    end else begin
      $display("ball_bounce_physics_step_test: errors");
    end
    $finish;
  end

endmodule
